@@ hdl/ctru_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctru_pkg
// shared types and constants for the copy text row unescaper
// ----------------------------------------------------------------------------
package ctru_pkg;

  localparam int COL_W  = 11;
  localparam int BYTE_W = 8;

  // raw byte codes
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_UPPER_N   = 8'h4E;
  localparam logic [7:0] CHAR_LOWER_B   = 8'h62;
  localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
  localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
  localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
  localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
  localparam logic [7:0] CHAR_LOWER_V   = 8'h76;

  // decoded control bytes
  localparam logic [7:0] CTRL_BS = 8'h08;
  localparam logic [7:0] CTRL_FF = 8'h0C;
  localparam logic [7:0] CTRL_LF = 8'h0A;
  localparam logic [7:0] CTRL_CR = 8'h0D;
  localparam logic [7:0] CTRL_HT = 8'h09;
  localparam logic [7:0] CTRL_VT = 8'h0B;

  // register indexes
  localparam logic REG_EXPECTED_COLUMNS = 1'b0;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_ESCAPE,
    MODE_NULL,
    MODE_DISCARD
  } ctru_mode_t;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_FIELD_END,
    KIND_ROW_END,
    KIND_ERROR
  } ctru_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_BAD_ESCAPE,
    ERR_NULL_NOT_FIRST,
    ERR_AFTER_NULL,
    ERR_COLUMNS
  } ctru_err_t;

  typedef struct packed {
    ctru_mode_t         mode;
    logic               field_started;
    logic [COL_W-1:0]   column_count;
  } ctru_state_t;

  typedef struct packed {
    ctru_kind_t         kind;
    logic [BYTE_W-1:0]  data_byte;
    logic               field_is_null;
    logic [COL_W-1:0]   column_index;
    ctru_err_t          error_code;
  } ctru_result_t;

endpackage

@@ hdl/ctru_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctru_decode
// per-byte decode: next row state and the result the byte causes
// ----------------------------------------------------------------------------
module ctru_decode #(
  parameter int MAX_COLUMNS = 2048
) (
  input  logic [ctru_pkg::BYTE_W-1:0] byte_i,
  input  ctru_pkg::ctru_state_t       state_i,
  input  logic [ctru_pkg::COL_W-1:0]  expected_columns_i,
  output ctru_pkg::ctru_state_t       state_o,
  output logic                        res_valid_o,
  output ctru_pkg::ctru_result_t      res_o
);

  localparam int CapInt = (MAX_COLUMNS - 1 < 2047) ? MAX_COLUMNS - 1 : 2047;
  localparam logic [ctru_pkg::COL_W-1:0] COL_CAP = ctru_pkg::COL_W'(CapInt);

  logic [ctru_pkg::COL_W-1:0] col_inc;
  logic                       esc_ok;
  logic [7:0]                 esc_byte;

  assign col_inc = (state_i.column_count >= COL_CAP) ? COL_CAP
                                                     : state_i.column_count + 11'd1;

  always_comb begin
    esc_ok   = 1'b1;
    esc_byte = ctru_pkg::CHAR_BACKSLASH;
    case (byte_i)
      ctru_pkg::CHAR_LOWER_B:   esc_byte = ctru_pkg::CTRL_BS;
      ctru_pkg::CHAR_LOWER_F:   esc_byte = ctru_pkg::CTRL_FF;
      ctru_pkg::CHAR_LOWER_N:   esc_byte = ctru_pkg::CTRL_LF;
      ctru_pkg::CHAR_LOWER_R:   esc_byte = ctru_pkg::CTRL_CR;
      ctru_pkg::CHAR_LOWER_T:   esc_byte = ctru_pkg::CTRL_HT;
      ctru_pkg::CHAR_LOWER_V:   esc_byte = ctru_pkg::CTRL_VT;
      ctru_pkg::CHAR_BACKSLASH: esc_byte = ctru_pkg::CHAR_BACKSLASH;
      default:                  esc_ok   = 1'b0;
    endcase
  end

  always_comb begin
    state_o                  = state_i;
    res_valid_o              = 1'b0;
    res_o.kind               = ctru_pkg::KIND_DATA;
    res_o.data_byte          = '0;
    res_o.field_is_null      = 1'b0;
    res_o.column_index       = state_i.column_count;
    res_o.error_code         = ctru_pkg::ERR_NONE;

    case (state_i.mode)
      ctru_pkg::MODE_NORMAL, ctru_pkg::MODE_NULL: begin
        if (byte_i == ctru_pkg::CHAR_TAB) begin
          res_valid_o           = 1'b1;
          res_o.kind            = ctru_pkg::KIND_FIELD_END;
          res_o.field_is_null   = (state_i.mode == ctru_pkg::MODE_NULL);
          state_o.column_count  = col_inc;
          state_o.field_started = 1'b0;
          state_o.mode          = ctru_pkg::MODE_NORMAL;
        end else if (byte_i == ctru_pkg::CHAR_NEWLINE) begin
          res_valid_o = 1'b1;
          if (col_inc != expected_columns_i) begin
            res_o.kind       = ctru_pkg::KIND_ERROR;
            res_o.error_code = ctru_pkg::ERR_COLUMNS;
          end else begin
            res_o.kind          = ctru_pkg::KIND_ROW_END;
            res_o.field_is_null = (state_i.mode == ctru_pkg::MODE_NULL);
          end
          state_o.column_count  = '0;
          state_o.field_started = 1'b0;
          state_o.mode          = ctru_pkg::MODE_NORMAL;
        end else if (state_i.mode == ctru_pkg::MODE_NULL) begin
          // anything else after a null marker
          res_valid_o      = 1'b1;
          res_o.kind       = ctru_pkg::KIND_ERROR;
          res_o.error_code = ctru_pkg::ERR_AFTER_NULL;
          state_o.mode     = ctru_pkg::MODE_DISCARD;
        end else if (byte_i == ctru_pkg::CHAR_BACKSLASH) begin
          state_o.mode = ctru_pkg::MODE_ESCAPE;
        end else begin
          res_valid_o           = 1'b1;
          res_o.data_byte       = byte_i;
          state_o.field_started = 1'b1;
        end
      end

      ctru_pkg::MODE_ESCAPE: begin
        if (byte_i == ctru_pkg::CHAR_UPPER_N) begin
          if (state_i.field_started) begin
            res_valid_o      = 1'b1;
            res_o.kind       = ctru_pkg::KIND_ERROR;
            res_o.error_code = ctru_pkg::ERR_NULL_NOT_FIRST;
            state_o.mode     = ctru_pkg::MODE_DISCARD;
          end else begin
            state_o.mode = ctru_pkg::MODE_NULL;
          end
        end else if (esc_ok) begin
          res_valid_o           = 1'b1;
          res_o.data_byte       = esc_byte;
          state_o.field_started = 1'b1;
          state_o.mode          = ctru_pkg::MODE_NORMAL;
        end else begin
          res_valid_o      = 1'b1;
          res_o.kind       = ctru_pkg::KIND_ERROR;
          res_o.error_code = ctru_pkg::ERR_BAD_ESCAPE;
          if (byte_i == ctru_pkg::CHAR_NEWLINE) begin
            // the newline still closes the row
            state_o.column_count  = '0;
            state_o.field_started = 1'b0;
            state_o.mode          = ctru_pkg::MODE_NORMAL;
          end else begin
            state_o.mode = ctru_pkg::MODE_DISCARD;
          end
        end
      end

      default: begin
        if (byte_i == ctru_pkg::CHAR_NEWLINE) begin
          state_o.column_count  = '0;
          state_o.field_started = 1'b0;
          state_o.mode          = ctru_pkg::MODE_NORMAL;
        end
      end
    endcase
  end

endmodule

@@ hdl/ctru_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctru_out_reg
// result register on the output stream
// ----------------------------------------------------------------------------
module ctru_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load_i,
  input  ctru_pkg::ctru_result_t res_i,
  input  logic                   ready_i,
  output logic                   free_o,
  output logic                   valid_o,
  output ctru_pkg::ctru_result_t res_o
);

  logic                   valid_r;
  logic                   valid_nxt;
  ctru_pkg::ctru_result_t res_r;

  // can take a new transaction when empty or being drained this cycle
  assign free_o    = !valid_r || ready_i;
  assign valid_nxt = load_i || (valid_r && !ready_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      res_r <= res_i;
    end
  end

  assign valid_o = valid_r;
  assign res_o   = res_r;

endmodule

@@ hdl/copy_text_row_unescaper.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// copy_text_row_unescaper
// byte-wide decoder for bulk-copy text rows with escape and column checking
// ----------------------------------------------------------------------------
// One raw byte enters per transaction and the block keeps up at one byte per
// clock while the output is not stalled. Each accepted byte sits in an input
// register while the decode logic works out the row state update and its
// result; the result then moves into the output register, which presents it
// on the result stream. Bytes that yield no result (a lone backslash, the N of
// a null marker, bytes skipped after an error) pass the input register alike
// and leave nothing on the output. The only stall comes from the output side:
// a byte waiting in the input register that has a result holds until the
// output register is free, and the input still takes a byte while a finished
// result waits to be taken. expected_columns is written over the APB port at
// byte address 0 and should only change while the stream is idle.
// ----------------------------------------------------------------------------
module copy_text_row_unescaper #(
  parameter int MAX_COLUMNS = 2048
) (
  input  logic        clk,
  input  logic        rst_n,

  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte

  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [7:0] data_byte, [8] field_is_null,
                                   // [19:9] column_index, [22:20] error_code,
                                   // [23] zero
  output logic [1:0]  out_tuser,   // [1:0] kind

  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration register
  logic [ctru_pkg::COL_W-1:0] expected_columns_r;
  logic                       cfg_write;

  // input register stage
  logic                        s1_valid_r;
  logic                        s1_valid_nxt;
  logic [ctru_pkg::BYTE_W-1:0] s1_byte_r;
  logic                        s1_advance;

  // row state
  ctru_pkg::ctru_state_t state_r;
  ctru_pkg::ctru_state_t state_nxt;

  // decode result and output register
  logic                   res_valid;
  ctru_pkg::ctru_result_t res;
  logic                   out_free;
  logic                   out_load;
  ctru_pkg::ctru_result_t out_res;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == ctru_pkg::REG_EXPECTED_COLUMNS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_columns_r <= '0;
    end else if (cfg_write) begin
      expected_columns_r <= cfg_pwdata[ctru_pkg::COL_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == ctru_pkg::REG_EXPECTED_COLUMNS) begin
      cfg_prdata = {21'd0, expected_columns_r};
    end
  end

  // ---------------- input register ----------------
  // the held byte moves on when it has no result or the output can take it
  assign s1_advance   = s1_valid_r && (!res_valid || out_free);
  assign in_tready    = !s1_valid_r || s1_advance;
  assign s1_valid_nxt = (in_tvalid && in_tready) || (s1_valid_r && !s1_advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
    end
  end

  // ---------------- decode ----------------
  ctru_decode #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_decode (
    .byte_i             (s1_byte_r),
    .state_i            (state_r),
    .expected_columns_i (expected_columns_r),
    .state_o            (state_nxt),
    .res_valid_o        (res_valid),
    .res_o              (res)
  );

  // row state only moves when the held byte is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode          <= ctru_pkg::MODE_NORMAL;
      state_r.field_started <= 1'b0;
      state_r.column_count  <= '0;
    end else if (s1_advance) begin
      state_r <= state_nxt;
    end
  end

  // ---------------- output register ----------------
  assign out_load = s1_advance && res_valid;

  ctru_out_reg u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .load_i  (out_load),
    .res_i   (res),
    .ready_i (out_tready),
    .free_o  (out_free),
    .valid_o (out_tvalid),
    .res_o   (out_res)
  );

  assign out_tuser = out_res.kind;
  assign out_tdata = {1'b0, out_res.error_code, out_res.column_index,
                      out_res.field_is_null, out_res.data_byte};

  // ---------------- assertions ----------------
  // input only stalls behind a full, stalled output
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_tvalid && !out_tready))
    else $error("input stalled without output back-pressure");

  // nothing comes out while skipping the rest of a bad row
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && state_r.mode == ctru_pkg::MODE_DISCARD) |-> !res_valid)
    else $error("result produced while discarding");

  // a byte with a result waiting on a stalled output stays held
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && res_valid && out_tvalid && !out_tready) |=> s1_valid_r)
    else $error("held byte lost while output stalled");

  // an error result always carries a code, other results never do
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_res.kind == ctru_pkg::KIND_ERROR) ==
                    (out_res.error_code != ctru_pkg::ERR_NONE)))
    else $error("error kind and code disagree");

  // a row that ends returns the column counter to zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res.kind == ctru_pkg::KIND_ROW_END) |=> (state_r.column_count == '0))
    else $error("column count not cleared at row end");

endmodule
